// ===== rtl/format_one_alu_with_status_flags_core_macros.svh =====
// ----------------------------------------------------------------------------
// format_one_alu_with_status_flags_core_macros
// Assertion macros for the ALU core; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FORMAT_ONE_ALU_WITH_STATUS_FLAGS_CORE_MACROS_SVH
`define FORMAT_ONE_ALU_WITH_STATUS_FLAGS_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define FOALU_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);
`define FOALU_ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);
`else
`define FOALU_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg)
`define FOALU_ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg)
`endif

`endif

// ===== rtl/foalu_pkg.sv =====
// ----------------------------------------------------------------------------
// foalu_pkg
// Types and constants shared by the ALU core and its execute unit.
// ----------------------------------------------------------------------------
package foalu_pkg;

  localparam int unsigned DataW = 16;

  typedef enum logic [3:0] {
    CMD_MOV  = 4'd0,
    CMD_ADD  = 4'd1,
    CMD_ADDC = 4'd2,
    CMD_SUB  = 4'd3,
    CMD_SUBC = 4'd4,
    CMD_CMP  = 4'd5,
    CMD_DADD = 4'd6,
    CMD_BIT  = 4'd7,
    CMD_BIC  = 4'd8,
    CMD_BIS  = 4'd9,
    CMD_XOR  = 4'd10,
    CMD_AND  = 4'd11
  } cmd_t;

  localparam logic [DataW-1:0] MaskByte = 16'h00FF;
  localparam logic [DataW-1:0] MaskWord = 16'hFFFF;
  localparam logic [DataW-1:0] SignByte = 16'h0080;
  localparam logic [DataW-1:0] SignWord = 16'h8000;
  localparam logic [4:0]       BcdMax   = 5'd9;
  localparam logic [3:0]       BcdAdj   = 4'd6;

  typedef struct packed {
    logic             [3:0] command;
    logic                   byte_mode;
    logic       [DataW-1:0] source_value;
    logic       [DataW-1:0] destination_value;
  } in_t;

  typedef struct packed {
    logic [DataW-1:0] result_value;
    logic             write_back;
    logic             flag_negative;
    logic             flag_zero;
    logic             flag_carry;
    logic             flag_overflow;
  } out_t;

  typedef struct packed {
    logic v;
    logic n;
    logic z;
    logic c;
  } flags_t;

endpackage

// ===== rtl/foalu_exec.sv =====
// ----------------------------------------------------------------------------
// foalu_exec
// Single-pass execute logic: result, write-back enable and next flags.
// ----------------------------------------------------------------------------
module foalu_exec (
  input  foalu_pkg::in_t    op_i,
  input  foalu_pkg::flags_t flags_i,
  output foalu_pkg::out_t   res_o,
  output foalu_pkg::flags_t flags_o
);
  import foalu_pkg::*;

  logic [DataW-1:0] mask;
  logic [DataW-1:0] sign;
  logic [DataW-1:0] src_m;
  logic [DataW-1:0] dst_m;
  logic [DataW-1:0] add_b;
  logic             add_cin;
  logic [DataW:0]   sum;
  logic [DataW-1:0] sum_r;
  logic             sum_c;
  logic             sum_v;
  logic [4:0]       dsum;
  logic             dc;
  logic             dc_lo;
  logic [DataW-1:0] bcd;
  logic [DataW-1:0] res;
  logic             wb;
  flags_t           fl;

  assign mask  = op_i.byte_mode ? MaskByte : MaskWord;
  assign sign  = op_i.byte_mode ? SignByte : SignWord;
  assign src_m = op_i.source_value & mask;
  assign dst_m = op_i.destination_value & mask;

  always_comb begin
    case (op_i.command)
      CMD_SUB, CMD_SUBC, CMD_CMP: add_b = ~src_m & mask;
      default:                    add_b = src_m;
    endcase
    case (op_i.command)
      CMD_ADDC, CMD_SUBC: add_cin = flags_i.c;
      CMD_SUB, CMD_CMP:   add_cin = 1'b1;
      default:            add_cin = 1'b0;
    endcase
  end

  assign sum   = {1'b0, dst_m} + {1'b0, add_b} + {{DataW{1'b0}}, add_cin};
  assign sum_r = sum[DataW-1:0] & mask;
  assign sum_c = op_i.byte_mode ? sum[8] : sum[DataW];
  assign sum_v = |((dst_m ^ sum_r) & (add_b ^ sum_r) & sign);

  always_comb begin
    dc    = flags_i.c;
    dc_lo = 1'b0;
    bcd   = '0;
    dsum  = '0;
    for (int i = 0; i < 4; i++) begin
      dsum = {1'b0, src_m[4*i +: 4]} + {1'b0, dst_m[4*i +: 4]} + {4'b0, dc};
      if (dsum > BcdMax) begin
        dc = 1'b1;
        bcd[4*i +: 4] = dsum[3:0] + BcdAdj;
      end else begin
        dc = 1'b0;
        bcd[4*i +: 4] = dsum[3:0];
      end
      if (i == 1) begin
        dc_lo = dc;
      end
    end
  end

  always_comb begin
    res = dst_m;
    wb  = 1'b1;
    fl  = flags_i;
    case (op_i.command)
      CMD_MOV: res = src_m;
      CMD_ADD, CMD_ADDC, CMD_SUB, CMD_SUBC, CMD_CMP: begin
        res  = sum_r;
        fl.n = |(sum_r & sign);
        fl.z = (sum_r == '0);
        fl.c = sum_c;
        fl.v = sum_v;
        if (op_i.command == CMD_CMP) begin
          wb = 1'b0;
        end
      end
      CMD_DADD: begin
        res  = bcd & mask;
        fl.n = |(res & sign);
        fl.z = (res == '0);
        fl.c = op_i.byte_mode ? dc_lo : dc;
        fl.v = 1'b0;
      end
      CMD_BIT, CMD_AND: begin
        res  = src_m & dst_m;
        fl.n = |(res & sign);
        fl.z = (res == '0);
        fl.c = (res != '0);
        fl.v = 1'b0;
        if (op_i.command == CMD_BIT) begin
          wb = 1'b0;
        end
      end
      CMD_BIC: res = dst_m & ~src_m & mask;
      CMD_BIS: res = dst_m | src_m;
      CMD_XOR: begin
        res  = src_m ^ dst_m;
        fl.n = |(res & sign);
        fl.z = (res == '0);
        fl.c = (res != '0);
        fl.v = |(src_m & dst_m & sign);
      end
      default: begin
        res = dst_m;
        wb  = 1'b0;
      end
    endcase
  end

  assign flags_o             = fl;
  assign res_o.result_value  = res;
  assign res_o.write_back    = wb;
  assign res_o.flag_negative = fl.n;
  assign res_o.flag_zero     = fl.z;
  assign res_o.flag_carry    = fl.c;
  assign res_o.flag_overflow = fl.v;

endmodule

// ===== rtl/format_one_alu_with_status_flags_core.sv =====
// Pipeline: an accepted input goes to the input register, then its result to
//   the result register.
// Throughput: one transaction per cycle while out_stall is low; execute logic
//   is one pass between the two registers, carry-in from the flag register.
// Reset: rst_n synchronous, active low; clears both valid bits and N, Z, C, V.
// ----------------------------------------------------------------------------
// format_one_alu_with_status_flags_core
// Two-operand 16-bit ALU with status flags and valid/stall channels.
// ----------------------------------------------------------------------------
`include "format_one_alu_with_status_flags_core_macros.svh"

module format_one_alu_with_status_flags_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  foalu_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output foalu_pkg::out_t  out_data
);
  import foalu_pkg::*;

  in_t    op_r;
  in_t    op_nxt;
  logic   op_valid_r;
  logic   op_valid_nxt;
  out_t   res_r;
  out_t   res_nxt;
  logic   res_valid_r;
  logic   res_valid_nxt;
  flags_t flags_r;
  flags_t flags_nxt;
  out_t   exec_res;
  flags_t exec_flags;
  logic   advance;
  logic   in_take;

  foalu_exec u_exec (
    .op_i    (op_r),
    .flags_i (flags_r),
    .res_o   (exec_res),
    .flags_o (exec_flags)
  );

  assign advance  = !res_valid_r || !out_stall;
  assign in_stall = op_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    op_nxt        = op_r;
    op_valid_nxt  = op_valid_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r;
    flags_nxt     = flags_r;
    if (advance) begin
      res_valid_nxt = op_valid_r;
      if (op_valid_r) begin
        res_nxt   = exec_res;
        flags_nxt = exec_flags;
      end
    end
    if (in_take) begin
      op_nxt       = in_data;
      op_valid_nxt = 1'b1;
    end else if (advance) begin
      op_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      op_valid_r  <= op_valid_nxt;
      res_valid_r <= res_valid_nxt;
      flags_r     <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    res_r <= res_nxt;
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

  `FOALU_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, in_stall,
    op_valid_r && res_valid_r && out_stall, "input stalled while a stage is free")
  `FOALU_ASSERT_NXT(a_flags_track_result, clk, rst_n, op_valid_r && advance,
    flags_r.n == res_r.flag_negative && flags_r.z == res_r.flag_zero &&
    flags_r.c == res_r.flag_carry && flags_r.v == res_r.flag_overflow,
    "flag register differs from delivered flags")
  `FOALU_ASSERT_NXT(a_flags_hold_idle, clk, rst_n, !(op_valid_r && advance),
    $stable(flags_r), "flags changed without an executed transaction")

endmodule
